/* src/vam_pkg.sv */
// ----------------------------------------------------------------------------
// vam_pkg
// Shared constants, types and the arctangent table of the vector angle and
// magnitude pipeline.
// ----------------------------------------------------------------------------
package vam_pkg;

    localparam int COORD_BITS     = 17;
    localparam int ROTATION_STEPS = 24;
    localparam int TABLE_LEN      = 40;
    localparam int STEPS          = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int GUARD_BITS     = 61 - COORD_BITS;
    localparam int XW             = 64;
    localparam int ACC_W          = 32;
    localparam int DIR_W          = 16;
    localparam int TAB_IDX_W      = $clog2(TABLE_LEN);
    localparam int IN_DATA_W      = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W     = ((DIR_W + COORD_BITS + 7) / 8) * 8;

    localparam logic [31:0]        INV_GAIN = 32'h9B74EDA8;
    localparam logic [ACC_W-1:0]   HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0]   DIR_ROUND = 32'h0000_8000;
    localparam logic [COORD_BITS:0] LEN_MAX  = (COORD_BITS + 1)'(92682);

    // rotation state carried from stage to stage
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [ACC_W-1:0]     acc;
        logic                 zero;
    } vam_vec_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turn(input logic [TAB_IDX_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            6'd0:    v = 32'd536870912;
            6'd1:    v = 32'd316933406;
            6'd2:    v = 32'd167458907;
            6'd3:    v = 32'd85004756;
            6'd4:    v = 32'd42667331;
            6'd5:    v = 32'd21354465;
            6'd6:    v = 32'd10679838;
            6'd7:    v = 32'd5340245;
            6'd8:    v = 32'd2670163;
            6'd9:    v = 32'd1335086;
            6'd10:   v = 32'd667544;
            6'd11:   v = 32'd333772;
            6'd12:   v = 32'd166886;
            6'd13:   v = 32'd83443;
            6'd14:   v = 32'd41722;
            6'd15:   v = 32'd20861;
            6'd16:   v = 32'd10430;
            6'd17:   v = 32'd5215;
            6'd18:   v = 32'd2608;
            6'd19:   v = 32'd1304;
            6'd20:   v = 32'd652;
            6'd21:   v = 32'd326;
            6'd22:   v = 32'd163;
            6'd23:   v = 32'd81;
            6'd24:   v = 32'd41;
            6'd25:   v = 32'd20;
            6'd26:   v = 32'd10;
            6'd27:   v = 32'd5;
            6'd28:   v = 32'd3;
            6'd29:   v = 32'd1;
            6'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/vector_angle_and_magnitude.sv */
// ----------------------------------------------------------------------------
// vector_angle_and_magnitude
// Converts a signed vector (delta_x, delta_y) into a 16-bit binary angle and
// its rounded Euclidean length with a pipelined vectoring rotator.
// ----------------------------------------------------------------------------
// A new word is taken every clock cycle while the pipeline advances. From an
// accepted input word to a valid output word the word passes one input
// stage, one register per micro-rotation, one multiply stage for the gain
// correction and the output register. The whole pipeline moves as one: it
// advances, and takes input, whenever the output register can load or the
// gain correction stage is empty. While the output word waits, input words
// still enter until a word reaches the gain correction stage; empty slots
// further up stay where they are until the output drains. The zero vector
// gives angle 0 and length 0; (negative, 0) gives angle 32768.
module vector_angle_and_magnitude (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // delta_x, delta_y, zero pad
    input  logic [vam_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // direction, length, zero pad
    output logic [vam_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import vam_pkg::*;

    logic             adv;
    logic             out_load;
    logic             prep_valid;
    vam_vec_t         prep_vec;
    logic             rot_valid;
    vam_vec_t         rot_vec;
    logic             mul_valid;
    logic [DIR_W-1:0] direction;
    logic [COORD_BITS-1:0] length;
    logic             m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    assign out_load      = !m_valid_reg || m_axis_tready;
    // the pipe moves when the output can load or the last stage is a bubble
    assign adv           = out_load || !mul_valid;
    assign s_axis_tready = adv;

    vam_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .delta_x   (s_axis_tdata[COORD_BITS-1:0]),
        .delta_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .valid_reg (prep_valid),
        .vec_reg   (prep_vec)
    );

    vam_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (prep_valid),
        .in_vec    (prep_vec),
        .out_valid (rot_valid),
        .out_vec   (rot_vec)
    );

    vam_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rot_valid),
        .in_vec    (rot_vec),
        .valid_reg (mul_valid),
        .direction (direction),
        .length    (length)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= mul_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && mul_valid)
            m_data_reg <= OUT_DATA_W'({length, direction});
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* src/vam_prep.sv */
// ----------------------------------------------------------------------------
// vam_prep
// Input stage: sign extends and scales the coordinates, folds the left half
// plane onto the right one and seeds the angle accumulator.
// ----------------------------------------------------------------------------
module vam_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [vam_pkg::COORD_BITS-1:0] delta_x,
    input  logic [vam_pkg::COORD_BITS-1:0] delta_y,
    output logic                        valid_reg,
    output vam_pkg::vam_vec_t           vec_reg
);
    import vam_pkg::*;

    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;
    vam_vec_t             vec_next;

    always_comb
    begin
        x_ext = XW'(signed'(delta_x)) <<< GUARD_BITS;
        y_ext = XW'(signed'(delta_y)) <<< GUARD_BITS;
        vec_next.zero = (delta_x == '0) && (delta_y == '0);
        if (x_ext < 0)
        begin
            vec_next.x   = -x_ext;
            vec_next.y   = -y_ext;
            vec_next.acc = HALF_TURN;
        end
        else
        begin
            vec_next.x   = x_ext;
            vec_next.y   = y_ext;
            vec_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            vec_reg <= vec_next;
    end

endmodule

/* src/vam_cordic.sv */
// ----------------------------------------------------------------------------
// vam_cordic
// Unrolled vectoring rotations, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module vam_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  vam_pkg::vam_vec_t in_vec,
    output logic              out_valid,
    output vam_pkg::vam_vec_t out_vec
);
    import vam_pkg::*;

    logic     valid_reg [1:STEPS];
    vam_vec_t vec_reg   [1:STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic     stage_valid;
            vam_vec_t stage_vec;
            vam_vec_t vec_next;

            if (i == 0)
            begin : g_first
                assign stage_valid = in_valid;
                assign stage_vec   = in_vec;
            end
            else
            begin : g_next
                assign stage_valid = valid_reg[i];
                assign stage_vec   = vec_reg[i];
            end

            // shift amount is fixed per stage, so the shifts are wiring
            always_comb
            begin
                vec_next.zero = stage_vec.zero;
                if (!stage_vec.y[XW-1])
                begin
                    vec_next.x   = stage_vec.x + (stage_vec.y >>> i);
                    vec_next.y   = stage_vec.y - (stage_vec.x >>> i);
                    vec_next.acc = stage_vec.acc + atan_turn(TAB_IDX_W'(i));
                end
                else
                begin
                    vec_next.x   = stage_vec.x - (stage_vec.y >>> i);
                    vec_next.y   = stage_vec.y + (stage_vec.x >>> i);
                    vec_next.acc = stage_vec.acc - atan_turn(TAB_IDX_W'(i));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i+1] <= 1'b0;
                else if (adv)
                    valid_reg[i+1] <= stage_valid;
            end

            always_ff @(posedge clk)
            begin
                if (adv && stage_valid)
                    vec_reg[i+1] <= vec_next;
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS];
    assign out_vec   = vec_reg[STEPS];

endmodule

/* src/vam_scale.sv */
// ----------------------------------------------------------------------------
// vam_scale
// Gain correction: registered partial products of x and the inverse gain,
// then the rounded length and the rounded direction.
// ----------------------------------------------------------------------------
module vam_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  vam_pkg::vam_vec_t             in_vec,
    output logic                          valid_reg,
    output logic [vam_pkg::DIR_W-1:0]     direction,
    output logic [vam_pkg::COORD_BITS-1:0] length
);
    import vam_pkg::*;

    logic [63:0]      lo_reg;
    logic [63:0]      hi_reg;
    logic [DIR_W-1:0] dir_reg;
    logic             zero_reg;
    logic [63:0]      lo_next;
    logic [63:0]      hi_next;
    logic [ACC_W-1:0] dir_sum;
    logic [63:0]      t_sum;
    logic [63:0]      t_rnd;

    always_comb
    begin
        lo_next = in_vec.x[31:0] * INV_GAIN;
        hi_next = in_vec.x[63:32] * INV_GAIN;
        dir_sum = in_vec.acc + DIR_ROUND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            dir_reg  <= dir_sum[ACC_W-1 -: DIR_W];
            zero_reg <= in_vec.zero;
        end
    end

    always_comb
    begin
        t_sum = hi_reg + (lo_reg >> 32);
        t_rnd = (t_sum + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (zero_reg)
        begin
            direction = '0;
            length    = '0;
        end
        else
        begin
            direction = dir_reg;
            length    = t_rnd[COORD_BITS-1:0];
        end
    end

endmodule

/* src/vam_checker.sv */
// ----------------------------------------------------------------------------
// vam_checker
// Port level checks of the vector angle and magnitude block.
// ----------------------------------------------------------------------------
module vam_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [vam_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [vam_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import vam_pkg::*;

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

    // with nothing waiting at the output the input side is open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // only the zero vector rounds to length zero, so a zero length carries direction zero
    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[DIR_W+COORD_BITS-1:DIR_W] == '0))
        |-> (m_axis_tdata[DIR_W-1:0] == '0))
        else $error("zero length with nonzero direction");

    // length never exceeds the diagonal of the input range
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[DIR_W+COORD_BITS-1:DIR_W]} <= LEN_MAX))
        else $error("length out of range");

    // an offered input word carries defined data
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tdata))
        else $error("unknown input word");

endmodule

bind vector_angle_and_magnitude vam_checker u_vam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
